@@ design/nse_pkg.sv @@
// ----------------------------------------------------------------------------
// nse_pkg
// Shared types and constants for the NetBIOS node-status name extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nse_pkg;

  // largest datagram that is parsed; later bytes are dropped
  localparam int MAX_PACKET = 576;
  localparam int POS_W      = $clog2(MAX_PACKET + 1);

  // rdata end position, clamped
  localparam int END_W = 11;
  localparam logic [END_W-1:0] END_MAX = '1;

  // name entry layout
  localparam int NAME_MAX   = 15;
  localparam int NAME_IDX_W = $clog2(NAME_MAX);
  localparam int CNT_W      = $clog2(NAME_MAX + 1);
  localparam int ENTRY_W    = 5;
  localparam logic [ENTRY_W-1:0] ENT_SUFFIX = 5'd15;
  localparam logic [ENTRY_W-1:0] ENT_FLAGS  = 5'd16;
  localparam logic [ENTRY_W-1:0] ENT_LAST   = 5'd17;

  // fixed answer field offsets
  localparam logic [ENTRY_W-1:0] FX_TYPE_HI = 5'd0;
  localparam logic [ENTRY_W-1:0] FX_TYPE_LO = 5'd1;
  localparam logic [ENTRY_W-1:0] FX_LEN_HI  = 5'd8;
  localparam logic [ENTRY_W-1:0] FX_LEN_LO  = 5'd9;

  // header and question positions
  localparam logic [POS_W-1:0] POS_ID_HI     = POS_W'(0);
  localparam logic [POS_W-1:0] POS_ID_LO     = POS_W'(1);
  localparam logic [POS_W-1:0] POS_HDR_LAST  = POS_W'(11);
  localparam logic [POS_W-1:0] POS_QNAME_LEN = POS_W'(12);
  localparam logic [POS_W-1:0] POS_Q_LAST    = POS_W'(49);
  localparam logic [POS_W-1:0] MIN_LEN       = POS_W'(12);

  localparam logic [7:0]  QNAME_LEN    = 8'h20;
  localparam logic [7:0]  SPACE_CHAR   = 8'h20;
  localparam logic [1:0]  PTR_MARK     = 2'b11;
  localparam logic [15:0] TYPE_NBSTAT  = 16'h0021;
  localparam int          GROUP_BIT    = 7;

  // summary queue between parser and emitter
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_LIMIT  = 1'd1;
  localparam logic [3:0]  LIMIT_RESET = 4'd15;

  typedef enum logic [3:0] {
    PH_HEAD,
    PH_QSKIP,
    PH_ANAME_FIRST,
    PH_ANAME_PTR,
    PH_LABEL_LEN,
    PH_LABEL_BODY,
    PH_FIXED,
    PH_COUNT,
    PH_ENTRY,
    PH_DONE,
    PH_FAIL
  } phase_t;

  typedef enum logic [2:0] {
    ST_FOUND,
    ST_SHORT,
    ST_QUESTION,
    ST_TRUNC,
    ST_TYPELEN,
    ST_NONAME
  } status_t;

  // one finished packet, as handed to the emitter
  typedef struct packed {
    status_t                     status;
    logic [CNT_W-1:0]            count;
    logic [NAME_MAX-1:0][7:0]    name;
  } summary_t;

endpackage

`default_nettype wire

@@ design/nse_front.sv @@
// ----------------------------------------------------------------------------
// nse_front
// Byte parser: walks the reply one byte per cycle while take is high and builds a packet summary.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nse_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [nse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nse_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             take,
  input  logic [7:0]                       data_byte,
  input  logic                             last_byte,
  output logic                             sum_valid,
  output nse_pkg::summary_t                sum_data
);
  import nse_pkg::*;

  logic [15:0]            expected_id;
  logic [3:0]             name_limit;

  phase_t                 phase, phase_next;
  logic [POS_W-1:0]       pos, pos_next;
  logic [7:0]             label_rem, label_rem_next;
  logic [15:0]            ans_type, ans_type_next;
  logic [END_W-1:0]       req_end, req_end_next;
  logic [7:0]             entries_rem, entries_rem_next;
  logic [ENTRY_W-1:0]     entry_off, entry_off_next;
  logic [CNT_W-1:0]       trim_len, trim_len_next;
  logic                   found, found_next;
  status_t                fail_code, fail_code_next;
  logic                   suffix_zero, suffix_zero_next;
  logic                   group_flag, group_flag_next;

  logic [NAME_MAX-1:0][7:0] name_store;
  logic                   name_we;
  logic [NAME_IDX_W-1:0]  name_widx;

  logic [15:0]            rdlen;
  logic [16:0]            rd_end;
  logic [7:0]             entries_dec;
  logic [END_W-1:0]       pkt_len;
  logic [CNT_W-1:0]       lim;
  logic [CNT_W-1:0]       n_chars;
  status_t                final_st;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= '0;
      name_limit  <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXPECTED_ID: expected_id <= cfg_data;
        CFG_NAME_LIMIT:  name_limit  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next       = phase;
    pos_next         = pos;
    label_rem_next   = label_rem;
    ans_type_next    = ans_type;
    req_end_next     = req_end;
    entries_rem_next = entries_rem;
    entry_off_next   = entry_off;
    trim_len_next    = trim_len;
    found_next       = found;
    fail_code_next   = fail_code;
    suffix_zero_next = suffix_zero;
    group_flag_next  = group_flag;
    name_we          = 1'b0;
    name_widx        = entry_off[NAME_IDX_W-1:0];
    rdlen            = {req_end[7:0], data_byte};
    rd_end           = 17'(pos) + 17'd1 + 17'(rdlen);
    entries_dec      = entries_rem - 8'd1;

    if (pos < POS_W'(MAX_PACKET)) begin
      pos_next = pos + POS_W'(1);
      case (phase)
        PH_HEAD: begin
          if (pos == POS_ID_HI && data_byte != expected_id[15:8]) begin
            fail_code_next = ST_SHORT;
            phase_next     = PH_FAIL;
          end else if (pos == POS_ID_LO && data_byte != expected_id[7:0]) begin
            fail_code_next = ST_SHORT;
            phase_next     = PH_FAIL;
          end else if (pos >= POS_HDR_LAST) begin
            phase_next = PH_QSKIP;
          end
        end
        PH_QSKIP: begin
          if (pos == POS_QNAME_LEN && data_byte != QNAME_LEN) begin
            fail_code_next = ST_QUESTION;
            phase_next     = PH_FAIL;
          end else if (pos >= POS_Q_LAST) begin
            phase_next = PH_ANAME_FIRST;
          end
        end
        PH_ANAME_FIRST: begin
          if (data_byte[7:6] == PTR_MARK) begin
            phase_next = PH_ANAME_PTR;
          end else if (data_byte == 8'd0) begin
            entry_off_next = '0;
            phase_next     = PH_FIXED;
          end else begin
            label_rem_next = data_byte;
            phase_next     = PH_LABEL_BODY;
          end
        end
        PH_ANAME_PTR: begin
          entry_off_next = '0;
          phase_next     = PH_FIXED;
        end
        PH_LABEL_LEN: begin
          // every nonzero byte is a length here, pointer marks included
          if (data_byte == 8'd0) begin
            entry_off_next = '0;
            phase_next     = PH_FIXED;
          end else begin
            label_rem_next = data_byte;
            phase_next     = PH_LABEL_BODY;
          end
        end
        PH_LABEL_BODY: begin
          label_rem_next = label_rem - 8'd1;
          if (label_rem == 8'd1) phase_next = PH_LABEL_LEN;
        end
        PH_FIXED: begin
          entry_off_next = entry_off + ENTRY_W'(1);
          case (entry_off)
            FX_TYPE_HI: ans_type_next = {data_byte, 8'd0};
            FX_TYPE_LO: ans_type_next = {ans_type[15:8], data_byte};
            FX_LEN_HI:  req_end_next  = END_W'(data_byte);
            FX_LEN_LO: begin
              if (ans_type != TYPE_NBSTAT || rdlen == 16'd0) begin
                fail_code_next = ST_TYPELEN;
                phase_next     = PH_FAIL;
              end else begin
                req_end_next = (rd_end > 17'(END_MAX)) ? END_MAX : rd_end[END_W-1:0];
                phase_next   = PH_COUNT;
              end
            end
            default: ;
          endcase
        end
        PH_COUNT: begin
          entries_rem_next = data_byte;
          entry_off_next   = '0;
          trim_len_next    = '0;
          phase_next       = (data_byte == 8'd0) ? PH_DONE : PH_ENTRY;
        end
        PH_ENTRY: begin
          if (entry_off < ENTRY_W'(NAME_MAX)) begin
            name_we = 1'b1;
            if (data_byte != SPACE_CHAR) begin
              trim_len_next = entry_off[CNT_W-1:0] + CNT_W'(1);
            end
          end else if (entry_off == ENT_SUFFIX) begin
            suffix_zero_next = (data_byte == 8'd0);
          end else if (entry_off == ENT_FLAGS) begin
            group_flag_next = data_byte[GROUP_BIT];
          end
          if (entry_off >= ENT_LAST) begin
            entry_off_next = '0;
            if (suffix_zero && !group_flag && trim_len != '0) begin
              found_next = 1'b1;
              phase_next = PH_DONE;
            end else begin
              entries_rem_next = entries_dec;
              if (entries_dec == 8'd0) begin
                phase_next = PH_DONE;
              end else begin
                trim_len_next = '0;
              end
            end
          end else begin
            entry_off_next = entry_off + ENTRY_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // end-of-packet verdict from the updated state
  always_comb begin
    pkt_len = END_W'(pos_next);
    if (phase_next == PH_FAIL) begin
      final_st = fail_code_next;
    end else if (pkt_len < END_W'(MIN_LEN) || phase_next == PH_HEAD) begin
      final_st = ST_SHORT;
    end else if (phase_next == PH_COUNT || phase_next == PH_ENTRY ||
                 phase_next == PH_DONE) begin
      if (req_end_next > pkt_len) final_st = ST_TYPELEN;
      else if (found_next)        final_st = ST_FOUND;
      else                        final_st = ST_NONAME;
    end else begin
      final_st = ST_TRUNC;
    end
    lim     = (name_limit == 4'd0) ? CNT_W'(1) : CNT_W'(name_limit);
    n_chars = (trim_len_next < lim) ? trim_len_next : lim;
  end

  assign sum_valid       = take && last_byte;
  assign sum_data.status = final_st;
  assign sum_data.count  = (final_st == ST_FOUND) ? n_chars : CNT_W'(1);
  assign sum_data.name   = name_store;

  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      phase       <= PH_HEAD;
      pos         <= '0;
      label_rem   <= '0;
      ans_type    <= '0;
      req_end     <= '0;
      entries_rem <= '0;
      entry_off   <= '0;
      trim_len    <= '0;
      found       <= 1'b0;
      fail_code   <= ST_FOUND;
      suffix_zero <= 1'b1;
      group_flag  <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      pos         <= pos_next;
      label_rem   <= label_rem_next;
      ans_type    <= ans_type_next;
      req_end     <= req_end_next;
      entries_rem <= entries_rem_next;
      entry_off   <= entry_off_next;
      trim_len    <= trim_len_next;
      found       <= found_next;
      fail_code   <= fail_code_next;
      suffix_zero <= suffix_zero_next;
      group_flag  <= group_flag_next;
    end
  end

  // name bytes hold no reset; only bytes of the kept entry are ever read
  always_ff @(posedge clk) begin
    if (take && name_we) begin
      name_store[name_widx] <= data_byte;
    end
  end

endmodule

`default_nettype wire

@@ design/nse_queue.sv @@
// ----------------------------------------------------------------------------
// nse_queue
// Short queue of packet summaries between the parser and the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nse_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  nse_pkg::summary_t  wr_data,
  input  logic               rd_en,
  output nse_pkg::summary_t  rd_data,
  output logic               q_full,
  output logic               q_empty
);
  import nse_pkg::*;

  summary_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0]     fill;
  logic                   do_wr, do_rd;

  assign q_full  = (fill == Q_CNT_W'(Q_DEPTH));
  assign q_empty = (fill == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   fill <= fill + Q_CNT_W'(1);
        2'b01:   fill <= fill - Q_CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

@@ design/nse_back.sv @@
// ----------------------------------------------------------------------------
// nse_back
// Result emitter: turns the oldest packet summary into result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nse_back (
  input  logic               clk,
  input  logic               rst,
  input  nse_pkg::summary_t  head,
  input  logic               head_valid,
  input  logic               pop,
  output logic               deq,
  output logic               empty,
  output logic [2:0]         status,
  output logic [7:0]         name_char,
  output logic               last_result
);
  import nse_pkg::*;

  logic [CNT_W-1:0]  idx;
  logic              taken;

  assign empty       = !head_valid;
  assign taken       = pop && head_valid;
  assign status      = head.status;
  assign last_result = (idx == head.count - CNT_W'(1));
  assign name_char   = (head.status == ST_FOUND) ? head.name[idx[NAME_IDX_W-1:0]] : 8'd0;
  assign deq         = taken && last_result;

  // character index within the current packet
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (taken) begin
      idx <= last_result ? '0 : idx + CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

@@ design/netbios_status_name_extractor.sv @@
// NetBIOS node-status name extractor. Reply bytes enter one per clock through
// push/full, with last_byte on the final byte of a datagram; bytes past
// MAX_PACKET are dropped but a last_byte mark on them still ends the packet.
// On the final byte the parser hands a summary to a two-entry queue, and the
// emitter drains it as result items: the name characters (up to name_limit)
// or one failure status, one item per cycle while pop is high, last_result
// on the final one. A new item is taken every cycle; full rises only while two
// finished packet summaries are waiting in the queue, which happens when the
// result side is slower than the incoming packets. Each packet summary is
// queued on its final byte and emitted after older ones. Configuration
// writes are always ready and should be made while no packet is in flight.
`timescale 1ns / 1ps
`default_nettype none

module netbios_status_name_extractor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nse_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       data_byte,
  input  logic                             last_byte,
  output logic                             empty,
  input  logic                             pop,
  output logic [2:0]                       status,
  output logic [7:0]                       name_char,
  output logic                             last_result
);
  import nse_pkg::*;

  logic      take;
  logic      sum_valid;
  summary_t  sum_data;
  summary_t  head;
  logic      q_full, q_empty;
  logic      deq;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign take      = push && !q_full;

  nse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .sum_valid (sum_valid),
    .sum_data  (sum_data)
  );

  nse_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (sum_valid),
    .wr_data (sum_data),
    .rd_en   (deq),
    .rd_data (head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  nse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (!q_empty),
    .pop         (pop),
    .deq         (deq),
    .empty       (empty),
    .status      (status),
    .name_char   (name_char),
    .last_result (last_result)
  );

endmodule

`default_nettype wire

@@ design/nse_checker.sv @@
// ----------------------------------------------------------------------------
// nse_checker
// Port-level checks on the result side of the name extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nse_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  logic        pop,
  input  logic [2:0]  status,
  input  logic [7:0]  name_char,
  input  logic        last_result
);
  import nse_pkg::*;

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(name_char) &&
                          $stable(last_result)))
    else $error("result changed while waiting");

  // a failure is reported as a single item
  a_fail_single: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_FOUND) |-> last_result)
    else $error("failure item not marked last");

  a_fail_char: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_FOUND) |-> (name_char == 8'd0))
    else $error("failure item carries a character");

  // name characters of one packet follow each other without a gap
  a_name_run: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last_result) |=> (!empty && status == ST_FOUND))
    else $error("name run broken");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (status == ST_FOUND || status == ST_SHORT || status == ST_QUESTION ||
                status == ST_TRUNC || status == ST_TYPELEN || status == ST_NONAME))
    else $error("status code out of range");

endmodule

bind netbios_status_name_extractor nse_checker u_nse_checker (.*);

`default_nettype wire
